>>> sv/link_command_parser_defines.svh
// ----------------------------------------------------------------------------
// Link command parser assertion macros
// Concurrent checks clocked on clk and held off during rst; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef LINK_COMMAND_PARSER_DEFINES_SVH
`define LINK_COMMAND_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// Check an expression at every clock edge outside reset.
`define LCP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition implies an expression in the following cycle.
`define LCP_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) cond |=> expr) else $error(msg);
`else
`define LCP_ASSERT(label, prop, msg)
`define LCP_ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

>>> sv/lcp_pkg.sv
// ----------------------------------------------------------------------------
// Link command parser package
// Character codes, command texts, matcher state and result word types.
// ----------------------------------------------------------------------------
`default_nettype none

package lcp_pkg;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_REPOWER   = 2'd1,
    ACT_POWER_OFF = 2'd2
  } action_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_S      = 8'h53;

  // Command text lengths; fed saturates one above the longest whole-line text
  localparam logic [3:0] START_LEN  = 4'd10;
  localparam logic [3:0] STOP_LEN   = 4'd9;
  localparam logic [3:0] STREAM_LEN = 4'd13;
  localparam logic [3:0] DISC_LEN   = 4'd12;
  localparam logic [3:0] FED_SAT    = 4'd11;

  // alive: [0] start command prefix live, [1] stop command prefix live,
  //        [2] stream-open text not yet found, [3] disconnect text not yet found
  typedef struct packed {
    logic [3:0] alive;
    logic [3:0] fed;
    logic [3:0] spos;
    logic [3:0] dpos;
    logic       zero_seen;
  } match_t;

  localparam match_t MATCH_CLEAR = '{alive: 4'hF, fed: 4'd0, spos: 4'd0,
                                     dpos: 4'd0, zero_seen: 1'b0};

  typedef struct packed {
    logic    connected;
    logic    streaming;
    logic    display;
    action_t action;
    logic    unknown;
  } apply_t;

  typedef struct packed {
    logic    command_mode;
    logic    link_connected;
    logic    stream_enabled;
    logic    display_enabled;
    action_t display_action;
    logic    unknown_command;
    logic    line_parsed;
  } res_t;

  function automatic logic [7:0] start_txt(input logic [3:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = "S";
      4'd1:    ch = "T";
      4'd2:    ch = "A";
      4'd3:    ch = "R";
      4'd4:    ch = "T";
      4'd5:    ch = "_";
      4'd6:    ch = "T";
      4'd7:    ch = "E";
      4'd8:    ch = "M";
      4'd9:    ch = "P";
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] stop_txt(input logic [3:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = "S";
      4'd1:    ch = "T";
      4'd2:    ch = "O";
      4'd3:    ch = "P";
      4'd4:    ch = "_";
      4'd5:    ch = "T";
      4'd6:    ch = "E";
      4'd7:    ch = "M";
      4'd8:    ch = "P";
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] stream_txt(input logic [3:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = "%";
      4'd1:    ch = "S";
      4'd2:    ch = "T";
      4'd3:    ch = "R";
      4'd4:    ch = "E";
      4'd5:    ch = "A";
      4'd6:    ch = "M";
      4'd7:    ch = "_";
      4'd8:    ch = "O";
      4'd9:    ch = "P";
      4'd10:   ch = "E";
      4'd11:   ch = "N";
      4'd12:   ch = "%";
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] disc_txt(input logic [3:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = "%";
      4'd1:    ch = "D";
      4'd2:    ch = "I";
      4'd3:    ch = "S";
      4'd4:    ch = "C";
      4'd5:    ch = "O";
      4'd6:    ch = "N";
      4'd7:    ch = "N";
      4'd8:    ch = "E";
      4'd9:    ch = "C";
      4'd10:   ch = "T";
      4'd11:   ch = "%";
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> sv/link_command_parser.sv
// ----------------------------------------------------------------------------
// Link command parser
// Escape-run tracking on the terminal side and line parsing on the link side.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word per byte, req_type 0 for a
//   terminal byte, 1 for a link byte, rx_byte the character. A word is taken
//   on a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): exactly one result word per input
//   word, in order, carrying the mode and flag state after that byte plus the
//   display action, unknown-command flag and line-parsed strobe.
//   The byte is held in an input register, parsed in a single combinational
//   pass against the parser state, and the result lands in the output
//   register. Throughput is one byte per cycle while the receiver does not
//   stall; the state update for a byte completes in the cycle it leaves the
//   input register, so the next byte follows directly.
//   While the receiver stalls, the result holds and one further byte may sit
//   in the input register; beyond that in_stall rises.
//   Reset clears both registers and returns the parser to normal mode with
//   an empty line, disconnected, not streaming and the display powered.
// ----------------------------------------------------------------------------
`default_nettype none

`include "link_command_parser_defines.svh"

module link_command_parser #(
  parameter int LINE_LIMIT = 63,
  parameter int ESCAPE_RUN = 3
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       req_type,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            command_mode,
  output logic            link_connected,
  output logic            stream_enabled,
  output logic            display_enabled,
  output logic [1:0]      display_action,
  output logic            unknown_command,
  output logic            line_parsed
);

  localparam int LIW   = $clog2(LINE_LIMIT + 1);
  localparam int RUN_W = $clog2(ESCAPE_RUN + 1);

  // Input register
  logic       s1_valid;
  logic       s1_req;
  logic [7:0] s1_byte;

  // Output register
  lcp_pkg::res_t res;
  lcp_pkg::res_t res_next;

  // Parser state
  logic             in_command_mode, in_command_mode_next;
  logic [RUN_W-1:0] dollar_run, dollar_run_next;
  logic [RUN_W-1:0] dash_run, dash_run_next;
  logic [LIW-1:0]   line_index, line_index_next;
  logic [7:0]       first_char, first_char_next;
  logic [7:0]       previous_char, previous_char_next;
  lcp_pkg::match_t  match, match_next;
  logic             connected_flag, connected_flag_next;
  logic             streaming_flag, streaming_flag_next;
  logic             display_flag, display_flag_next;

  logic advance;

  // Feed one byte into the incremental matchers.
  function automatic lcp_pkg::match_t match_feed(input lcp_pkg::match_t m,
                                                 input logic [7:0] c);
    lcp_pkg::match_t r;
    r = m;
    if (!m.zero_seen) begin
      if (c == lcp_pkg::CH_NUL) begin
        r.zero_seen = 1'b1;
      end else begin
        if (m.alive[0] && !(m.fed < lcp_pkg::START_LEN && c == lcp_pkg::start_txt(m.fed)))
          r.alive[0] = 1'b0;
        if (m.alive[1] && !(m.fed < lcp_pkg::STOP_LEN && c == lcp_pkg::stop_txt(m.fed)))
          r.alive[1] = 1'b0;
        if (m.fed != lcp_pkg::FED_SAT)
          r.fed = m.fed + 4'd1;
        if (m.alive[2]) begin
          if (m.spos < lcp_pkg::STREAM_LEN && c == lcp_pkg::stream_txt(m.spos))
            r.spos = m.spos + 4'd1;
          else
            r.spos = (c == lcp_pkg::CH_PCT) ? 4'd1 : 4'd0;
          if (r.spos >= lcp_pkg::STREAM_LEN)
            r.alive[2] = 1'b0;
        end
        if (m.alive[3]) begin
          if (m.dpos < lcp_pkg::DISC_LEN && c == lcp_pkg::disc_txt(m.dpos))
            r.dpos = m.dpos + 4'd1;
          else
            r.dpos = (c == lcp_pkg::CH_PCT) ? 4'd1 : 4'd0;
          if (r.dpos >= lcp_pkg::DISC_LEN)
            r.alive[3] = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Act on a finished line: update the flags and pick the display action.
  function automatic lcp_pkg::apply_t apply_line(input lcp_pkg::match_t m,
                                                 input logic [7:0] first,
                                                 input logic conn,
                                                 input logic strm,
                                                 input logic disp);
    lcp_pkg::apply_t a;
    a.connected = conn;
    a.streaming = strm;
    a.display   = disp;
    a.action    = lcp_pkg::ACT_NONE;
    a.unknown   = 1'b0;
    if (first == lcp_pkg::CH_PCT) begin
      if (!m.alive[2]) begin
        a.connected = 1'b1;
        if (!disp) begin
          a.action  = lcp_pkg::ACT_REPOWER;
          a.display = 1'b1;
        end
      end else if (!m.alive[3]) begin
        a.connected = 1'b0;
        a.streaming = 1'b0;
        a.action    = lcp_pkg::ACT_POWER_OFF;
        a.display   = 1'b0;
      end
    end else if (first == lcp_pkg::CH_S) begin
      if (m.alive[0] && m.fed == lcp_pkg::START_LEN) begin
        if (conn)
          a.streaming = 1'b1;
      end else if (m.alive[1] && m.fed == lcp_pkg::STOP_LEN) begin
        a.streaming = 1'b0;
      end
    end else begin
      a.unknown = 1'b1;
    end
    return a;
  endfunction

  // Advance the input register whenever the output register is free or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_req  <= req_type;
      s1_byte <= rx_byte;
    end
  end

  // Single parsing pass over the held byte
  always_comb begin
    logic [RUN_W-1:0] run_inc;
    logic [LIW-1:0]   pos;
    logic [7:0]       first;
    lcp_pkg::match_t  mbase;
    lcp_pkg::match_t  mfed;
    lcp_pkg::apply_t  ap;
    logic             parsed;
    lcp_pkg::action_t act;
    logic             unk;

    in_command_mode_next = in_command_mode;
    dollar_run_next      = dollar_run;
    dash_run_next        = dash_run;
    line_index_next      = line_index;
    first_char_next      = first_char;
    previous_char_next   = previous_char;
    match_next           = match;
    connected_flag_next  = connected_flag;
    streaming_flag_next  = streaming_flag;
    display_flag_next    = display_flag;
    parsed               = 1'b0;
    act                  = lcp_pkg::ACT_NONE;
    unk                  = 1'b0;
    run_inc              = '0;
    pos                  = '0;
    first                = first_char;
    mbase                = match;
    mfed                 = match;
    ap                   = '0;

    if (!s1_req) begin
      // Terminal side: count escape runs
      if (s1_byte == lcp_pkg::CH_DOLLAR) begin
        run_inc = dollar_run + 1'b1;
        if (run_inc >= RUN_W'(ESCAPE_RUN)) begin
          in_command_mode_next = 1'b1;
          dollar_run_next      = '0;
        end else begin
          dollar_run_next = run_inc;
        end
      end else begin
        dollar_run_next = '0;
      end
      if (in_command_mode_next && s1_byte == lcp_pkg::CH_DASH) begin
        run_inc = dash_run + 1'b1;
        if (run_inc >= RUN_W'(ESCAPE_RUN)) begin
          in_command_mode_next = 1'b0;
          dash_run_next        = '0;
          line_index_next      = '0;
        end else begin
          dash_run_next = run_inc;
        end
      end else begin
        dash_run_next = '0;
      end
    end else if (!in_command_mode) begin
      // Link side: wrap a full line, then build and match
      pos             = (line_index >= LIW'(LINE_LIMIT)) ? '0 : line_index;
      line_index_next = pos + 1'b1;
      if (pos == '0) begin
        first = s1_byte;
        mbase = lcp_pkg::MATCH_CLEAR;
      end
      first_char_next = first;
      if (s1_byte == lcp_pkg::CH_LF && pos != '0 && previous_char == lcp_pkg::CH_CR) begin
        // CR LF: judge the line without the CR
        match_next      = mbase;
        ap              = apply_line(mbase, first, connected_flag, streaming_flag,
                                     display_flag);
        parsed          = 1'b1;
        line_index_next = '0;
      end else begin
        mfed       = (pos != '0) ? match_feed(mbase, previous_char) : mbase;
        match_next = mfed;
        if (pos != '0 && s1_byte == lcp_pkg::CH_PCT && first == lcp_pkg::CH_PCT) begin
          // Closing percent is part of the line
          ap              = apply_line(match_feed(mfed, s1_byte), first, connected_flag,
                                       streaming_flag, display_flag);
          parsed          = 1'b1;
          line_index_next = '0;
        end
      end
      previous_char_next = s1_byte;
    end

    if (parsed) begin
      connected_flag_next = ap.connected;
      streaming_flag_next = ap.streaming;
      display_flag_next   = ap.display;
      act                 = ap.action;
      unk                 = ap.unknown;
    end

    res_next.command_mode    = in_command_mode_next;
    res_next.link_connected  = connected_flag_next;
    res_next.stream_enabled  = streaming_flag_next;
    res_next.display_enabled = display_flag_next;
    res_next.display_action  = act;
    res_next.unknown_command = unk;
    res_next.line_parsed     = parsed;
  end

  // Commit state when the byte leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_command_mode <= 1'b0;
      dollar_run      <= '0;
      dash_run        <= '0;
      line_index      <= '0;
      first_char      <= lcp_pkg::CH_NUL;
      previous_char   <= lcp_pkg::CH_NUL;
      match           <= lcp_pkg::MATCH_CLEAR;
      connected_flag  <= 1'b0;
      streaming_flag  <= 1'b0;
      display_flag    <= 1'b1;
    end else if (advance) begin
      in_command_mode <= in_command_mode_next;
      dollar_run      <= dollar_run_next;
      dash_run        <= dash_run_next;
      line_index      <= line_index_next;
      first_char      <= first_char_next;
      previous_char   <= previous_char_next;
      match           <= match_next;
      connected_flag  <= connected_flag_next;
      streaming_flag  <= streaming_flag_next;
      display_flag    <= display_flag_next;
    end
  end

  // Output register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign command_mode    = res.command_mode;
  assign link_connected  = res.link_connected;
  assign stream_enabled  = res.stream_enabled;
  assign display_enabled = res.display_enabled;
  assign display_action  = res.display_action;
  assign unknown_command = res.unknown_command;
  assign line_parsed     = res.line_parsed;

  // Assertions
  `LCP_ASSERT(a_strobe_only_on_parse, (out_valid && !line_parsed) |-> (display_action == lcp_pkg::ACT_NONE && !unknown_command), "action or unknown flag without a parsed line")
  `LCP_ASSERT(a_stream_needs_link, streaming_flag |-> connected_flag, "streaming while disconnected")
  `LCP_ASSERT(a_index_bound, line_index <= LIW'(LINE_LIMIT), "line index beyond line limit")
  `LCP_ASSERT(a_power_off_flags, (out_valid && display_action == lcp_pkg::ACT_POWER_OFF) |-> (!display_enabled && !link_connected && !stream_enabled), "power-off action with flags still set")
  `LCP_ASSERT_NEXT(a_repower_flags, (advance && res_next.display_action == lcp_pkg::ACT_REPOWER), (display_flag && connected_flag), "repower action without display and link flags")

endmodule

`default_nettype wire

>>> sim/link_command_parser_tb.sv
// ============================================================================
// Link command parser testbench
// Drives terminal and link bytes through the parser and checks every result
// word against a behavioural predictor. A directed table opens the run, then
// command lines, broken lines, overlong lines and escape runs follow at random.
// ============================================================================
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape
  localparam int WORD_TARGET    = 500;
  localparam int PHASE_ONE_END  = 220;
  localparam int PHASE_TWO_END  = 360;
  localparam int LONG_HOLD      = 80;
  localparam int TAIL_CYCLES    = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  // Parser shape, as the block is built by default
  localparam int LINE_MAX   = 63;
  localparam int ESC_RUN    = 3;

  // Command texts, right-aligned in a fixed-width vector
  localparam int TXT_W     = 16;
  localparam int START_N   = 10;
  localparam int STOP_N    = 9;
  localparam int STREAM_N  = 13;
  localparam int DISC_N    = 12;
  localparam logic [8*TXT_W-1:0] START_TXT  = {"START", "_TEMP"};
  localparam logic [8*TXT_W-1:0] STOP_TXT   = {"STOP", "_TEMP"};
  localparam logic [8*TXT_W-1:0] STREAM_TXT = {"%STREAM", "_OPEN%"};
  localparam logic [8*TXT_W-1:0] DISC_TXT   = "%DISCONNECT%";

  // Bits of the command hunt mask
  localparam int HUNT_START  = 0;
  localparam int HUNT_STOP   = 1;
  localparam int HUNT_STREAM = 2;
  localparam int HUNT_DISC   = 3;

  localparam logic REQ_TERMINAL = 1'b0;
  localparam logic REQ_LINK     = 1'b1;

  typedef struct packed {
    logic [3:0] alive;
    logic [7:0] fed;
    logic [3:0] spos;
    logic [3:0] dpos;
    logic       zero;
  } scan_t;

  localparam scan_t SCAN_FRESH = '{alive: 4'hF, fed: 8'd0, spos: 4'd0,
                                   dpos: 4'd0, zero: 1'b0};

  typedef struct {
    logic          from_link;
    logic [7:0]    ch;
    logic          typed;
    lcp_pkg::res_t want;
  } step_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       req_type;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       command_mode;
  logic       link_connected;
  logic       stream_enabled;
  logic       display_enabled;
  logic [1:0] display_action;
  logic       unknown_command;
  logic       line_parsed;

  always #2 clk = ~clk;

  link_command_parser dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .command_mode    (command_mode),
    .link_connected  (link_connected),
    .stream_enabled  (stream_enabled),
    .display_enabled (display_enabled),
    .display_action  (display_action),
    .unknown_command (unknown_command),
    .line_parsed     (line_parsed)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of what the parser holds
  // --------------------------------------------------------------------------
  logic       in_cmd    = 1'b0;
  int         dollars   = 0;
  int         dashes    = 0;
  int         line_len  = 0;
  logic [7:0] lead_ch   = lcp_pkg::CH_NUL;
  logic [7:0] last_ch   = lcp_pkg::CH_NUL;
  scan_t      scan      = SCAN_FRESH;
  logic       conn_f    = 1'b0;
  logic       strm_f    = 1'b0;
  logic       disp_f    = 1'b1;

  // Expected result words, oldest first
  lcp_pkg::res_t pending[$];

  // Bookkeeping shared between the stimulus, the receiver and the checker
  int            src_idle_pct = 37;
  int            rcv_idle_pct = 65;
  int            holds_asked  = 0;
  int            holds_served = 0;
  int            words_sent   = 0;
  int            results_seen = 0;
  int            lines_seen   = 0;
  int            actions_seen = 0;
  int            unknown_seen = 0;
  int            mode_entries = 0;
  int            mismatches   = 0;
  int            quiet_cycles = 0;
  logic          row_typed    = 1'b0;
  lcp_pkg::res_t row_want;
  logic [7:0]    line_buf[$];
  step_row_t     steps[$];

  // Character i of a command text of length n
  function automatic logic [7:0] txt_char(logic [8*TXT_W-1:0] txt, int n, int i);
    return txt[8*(n-1-i) +: 8];
  endfunction

  // Advance the command hunt by one line byte; a zero byte ends the text
  function automatic scan_t scan_feed(scan_t s, logic [7:0] c);
    scan_t n;
    n = s;
    if (n.zero) return n;
    if (c == lcp_pkg::CH_NUL) begin
      n.zero = 1'b1;
      return n;
    end
    if (n.alive[HUNT_START] && !(n.fed < START_N && c == txt_char(START_TXT, START_N, n.fed)))
      n.alive[HUNT_START] = 1'b0;
    if (n.alive[HUNT_STOP] && !(n.fed < STOP_N && c == txt_char(STOP_TXT, STOP_N, n.fed)))
      n.alive[HUNT_STOP] = 1'b0;
    if (n.fed != 8'hFF) n.fed = n.fed + 8'd1;
    // Substring hunts restart on a '%' so that the text may sit anywhere
    if (n.alive[HUNT_STREAM]) begin
      if (n.spos < STREAM_N && c == txt_char(STREAM_TXT, STREAM_N, n.spos))
        n.spos = n.spos + 4'd1;
      else
        n.spos = (c == lcp_pkg::CH_PCT) ? 4'd1 : 4'd0;
      if (n.spos >= STREAM_N) n.alive[HUNT_STREAM] = 1'b0;
    end
    if (n.alive[HUNT_DISC]) begin
      if (n.dpos < DISC_N && c == txt_char(DISC_TXT, DISC_N, n.dpos))
        n.dpos = n.dpos + 4'd1;
      else
        n.dpos = (c == lcp_pkg::CH_PCT) ? 4'd1 : 4'd0;
      if (n.dpos >= DISC_N) n.alive[HUNT_DISC] = 1'b0;
    end
    return n;
  endfunction

  // Act on a finished line and update the flags
  function automatic lcp_pkg::action_t close_line(scan_t s, output logic unk);
    lcp_pkg::action_t act;
    act = lcp_pkg::ACT_NONE;
    unk = 1'b0;
    if (lead_ch == lcp_pkg::CH_PCT) begin
      if (!s.alive[HUNT_STREAM]) begin
        conn_f = 1'b1;
        if (!disp_f) begin
          act    = lcp_pkg::ACT_REPOWER;
          disp_f = 1'b1;
        end
      end else if (!s.alive[HUNT_DISC]) begin
        // Disconnect always powers the display off, even when already off
        conn_f = 1'b0;
        strm_f = 1'b0;
        act    = lcp_pkg::ACT_POWER_OFF;
        disp_f = 1'b0;
      end
    end else if (lead_ch == lcp_pkg::CH_S) begin
      if (s.alive[HUNT_START] && s.fed == START_N) begin
        if (conn_f) strm_f = 1'b1;
      end else if (s.alive[HUNT_STOP] && s.fed == STOP_N) begin
        strm_f = 1'b0;
      end
    end else begin
      unk = 1'b1;
    end
    return act;
  endfunction

  // Work out the result word for one accepted byte
  function automatic lcp_pkg::res_t parse_byte(logic from_link, logic [7:0] c);
    lcp_pkg::res_t    r;
    lcp_pkg::action_t act;
    logic             unk;
    logic             done;
    int               pos;
    scan_t            peek;
    act  = lcp_pkg::ACT_NONE;
    unk  = 1'b0;
    done = 1'b0;
    if (!from_link) begin
      if (c == lcp_pkg::CH_DOLLAR) begin
        dollars++;
        if (dollars >= ESC_RUN) begin
          in_cmd  = 1'b1;
          dollars = 0;
        end
      end else begin
        dollars = 0;
      end
      if (in_cmd && c == lcp_pkg::CH_DASH) begin
        dashes++;
        if (dashes >= ESC_RUN) begin
          in_cmd   = 1'b0;
          dashes   = 0;
          line_len = 0;
        end
      end else begin
        dashes = 0;
      end
    end else if (!in_cmd) begin
      // An overfull line wraps to a fresh one without being parsed
      if (line_len >= LINE_MAX) line_len = 0;
      pos = line_len;
      line_len++;
      if (pos == 0) begin
        scan    = SCAN_FRESH;
        lead_ch = c;
      end
      if (c == lcp_pkg::CH_LF && pos >= 1 && last_ch == lcp_pkg::CH_CR) begin
        // The hunt lags a byte behind, so the CR never reaches it
        act      = close_line(scan, unk);
        done     = 1'b1;
        line_len = 0;
      end else begin
        if (pos >= 1) scan = scan_feed(scan, last_ch);
        if (pos >= 1 && c == lcp_pkg::CH_PCT && lead_ch == lcp_pkg::CH_PCT) begin
          // The closing '%' belongs to the line, so feed it to a copy
          peek     = scan_feed(scan, c);
          act      = close_line(peek, unk);
          done     = 1'b1;
          line_len = 0;
        end
      end
      last_ch = c;
    end
    r.command_mode    = in_cmd;
    r.link_connected  = conn_f;
    r.stream_enabled  = strm_f;
    r.display_enabled = disp_f;
    r.display_action  = act;
    r.unknown_command = unk;
    r.line_parsed     = done;
    return r;
  endfunction

  function automatic string show(lcp_pkg::res_t r);
    return $sformatf("mode=%b conn=%b strm=%b disp=%b act=%0d unk=%b parsed=%b",
                     r.command_mode, r.link_connected, r.stream_enabled,
                     r.display_enabled, r.display_action, r.unknown_command,
                     r.line_parsed);
  endfunction

  task automatic note_mismatch(string why, lcp_pkg::res_t w, lcp_pkg::res_t g);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t ns: %s: expected %s, got %s", $time, why, show(w), show(g));
  endtask

  // --------------------------------------------------------------------------
  // Checker: take accepted input words into the predictor first, then match
  // accepted result words against the oldest expectation. Both are sampled
  // at the rising edge, so the order of the two branches is fixed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_words
    lcp_pkg::res_t want;
    lcp_pkg::res_t got;
    logic          was_cmd;
    if (!rst && in_valid && !in_stall) begin
      was_cmd = in_cmd;
      want = parse_byte(req_type, rx_byte);
      if (want.command_mode && !was_cmd) mode_entries++;
      // Directed rows carry a hand-written expectation; use it in place
      if (row_typed) want = row_want;
      pending.push_back(want);
    end
    if (!rst && out_valid && !out_stall) begin
      got.command_mode    = command_mode;
      got.link_connected  = link_connected;
      got.stream_enabled  = stream_enabled;
      got.display_enabled = display_enabled;
      got.display_action  = lcp_pkg::action_t'(display_action);
      got.unknown_command = unknown_command;
      got.line_parsed     = line_parsed;
      if (pending.size() == 0) begin
        note_mismatch("result word with nothing pending", got, got);
      end else begin
        want = pending.pop_front();
        results_seen++;
        if (want.line_parsed) lines_seen++;
        if (want.display_action != lcp_pkg::ACT_NONE) actions_seen++;
        if (want.unknown_command) unknown_seen++;
        if (got.command_mode    !== want.command_mode    ||
            got.link_connected  !== want.link_connected  ||
            got.stream_enabled  !== want.stream_enabled  ||
            got.display_enabled !== want.display_enabled ||
            got.display_action  !== want.display_action  ||
            got.unknown_command !== want.unknown_command ||
            got.line_parsed     !== want.line_parsed)
          note_mismatch("result word differs", want, got);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall at random, and serve each long hold-off request by holding
  // stall high for a counted stretch while the sender keeps offering words.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int k;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        for (k = 0; k < LONG_HOLD; k++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers. Each call starts and ends at a falling edge; valid is
  // either held for the next word or dropped for a gap, never both.
  // --------------------------------------------------------------------------
  task automatic put_word(logic from_link, logic [7:0] ch);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= from_link;
    rx_byte  <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Bytes that stir the parser: raw values, command letters and line marks
  function automatic logic [7:0] noise_byte();
    logic [7:0] ch;
    case ($urandom_range(0, 5))
      0, 1:    ch = 8'($urandom_range(0, 255));
      2:       ch = txt_char(START_TXT, START_N, $urandom_range(0, START_N - 1));
      3:       ch = txt_char(DISC_TXT, DISC_N, $urandom_range(0, DISC_N - 1));
      4:       ch = lcp_pkg::CH_PCT;
      default: ch = lcp_pkg::CH_CR;
    endcase
    return ch;
  endfunction

  task automatic load_text(logic [8*TXT_W-1:0] txt, int n);
    int i;
    for (i = 0; i < n; i++) line_buf.push_back(txt_char(txt, n, i));
  endtask

  // Send the buffered line on the link side, now and then slipping a
  // terminal byte in between, then empty the buffer
  task automatic flush_line();
    int i;
    for (i = 0; i < line_buf.size(); i++) begin
      if ($urandom_range(0, 19) == 0) put_word(REQ_TERMINAL, noise_byte());
      put_word(REQ_LINK, line_buf[i]);
    end
    line_buf.delete();
  endtask

  function automatic lcp_pkg::res_t idle_flags(logic mode, logic unk, logic parsed);
    lcp_pkg::res_t r;
    r.command_mode    = mode;
    r.link_connected  = 1'b0;
    r.stream_enabled  = 1'b0;
    r.display_enabled = 1'b1;
    r.display_action  = lcp_pkg::ACT_NONE;
    r.unknown_command = unk;
    r.line_parsed     = parsed;
    return r;
  endfunction

  task automatic add_step(logic from_link, logic [7:0] ch, logic typed,
                          lcp_pkg::res_t want);
    step_row_t row;
    row.from_link = from_link;
    row.ch        = ch;
    row.typed     = typed;
    row.want      = want;
    steps.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    int idx;
    lcp_pkg::res_t none;
    none     = idle_flags(1'b0, 1'b0, 1'b0);
    row_want = none;
    rst      = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_TERMINAL;
    rx_byte  = lcp_pkg::CH_NUL;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. Flags stay at their reset values throughout, so the
    // expected words can be written out by hand.
    // Enter command mode on three dollars; link bytes are dropped there
    add_step(REQ_TERMINAL, lcp_pkg::CH_DOLLAR, 1'b1, idle_flags(1'b0, 1'b0, 1'b0));
    add_step(REQ_TERMINAL, lcp_pkg::CH_DOLLAR, 1'b1, idle_flags(1'b0, 1'b0, 1'b0));
    add_step(REQ_TERMINAL, lcp_pkg::CH_DOLLAR, 1'b1, idle_flags(1'b1, 1'b0, 1'b0));
    add_step(REQ_LINK,     "A",                1'b1, idle_flags(1'b1, 1'b0, 1'b0));
    add_step(REQ_LINK,     8'hFF,              1'b1, idle_flags(1'b1, 1'b0, 1'b0));
    // A broken dash run does not leave; three in a row do
    add_step(REQ_TERMINAL, lcp_pkg::CH_DASH,   1'b1, idle_flags(1'b1, 1'b0, 1'b0));
    add_step(REQ_TERMINAL, lcp_pkg::CH_DASH,   1'b1, idle_flags(1'b1, 1'b0, 1'b0));
    add_step(REQ_TERMINAL, 8'h00,              1'b1, idle_flags(1'b1, 1'b0, 1'b0));
    add_step(REQ_TERMINAL, lcp_pkg::CH_DASH,   1'b1, idle_flags(1'b1, 1'b0, 1'b0));
    add_step(REQ_TERMINAL, lcp_pkg::CH_DASH,   1'b1, idle_flags(1'b1, 1'b0, 1'b0));
    add_step(REQ_TERMINAL, lcp_pkg::CH_DASH,   1'b1, idle_flags(1'b0, 1'b0, 1'b0));
    // Dash outside command mode does nothing
    add_step(REQ_TERMINAL, lcp_pkg::CH_DASH,   1'b1, idle_flags(1'b0, 1'b0, 1'b0));
    // LF as the first byte cannot close a line; the CR LF after it does
    add_step(REQ_LINK,     lcp_pkg::CH_LF,     1'b1, idle_flags(1'b0, 1'b0, 1'b0));
    add_step(REQ_LINK,     lcp_pkg::CH_CR,     1'b1, idle_flags(1'b0, 1'b0, 1'b0));
    add_step(REQ_LINK,     lcp_pkg::CH_LF,     1'b1, idle_flags(1'b0, 1'b1, 1'b1));
    // Zero as the first byte gives an unknown line
    add_step(REQ_LINK,     lcp_pkg::CH_NUL,    1'b1, idle_flags(1'b0, 1'b0, 1'b0));
    add_step(REQ_LINK,     lcp_pkg::CH_CR,     1'b1, idle_flags(1'b0, 1'b0, 1'b0));
    add_step(REQ_LINK,     lcp_pkg::CH_LF,     1'b1, idle_flags(1'b0, 1'b1, 1'b1));
    // Empty percent line: known, parsed, no command
    add_step(REQ_LINK,     lcp_pkg::CH_PCT,    1'b0, none);
    add_step(REQ_LINK,     lcp_pkg::CH_PCT,    1'b1, idle_flags(1'b0, 1'b0, 1'b1));
    // S line cut short by a zero byte: known, parsed, no command
    add_step(REQ_LINK,     lcp_pkg::CH_S,      1'b0, none);
    add_step(REQ_LINK,     lcp_pkg::CH_NUL,    1'b0, none);
    add_step(REQ_LINK,     lcp_pkg::CH_CR,     1'b0, none);
    add_step(REQ_LINK,     lcp_pkg::CH_LF,     1'b1, idle_flags(1'b0, 1'b0, 1'b1));
    // Top byte value heading a line is unknown
    add_step(REQ_LINK,     8'hFF,              1'b0, none);
    add_step(REQ_LINK,     lcp_pkg::CH_CR,     1'b0, none);
    add_step(REQ_LINK,     lcp_pkg::CH_LF,     1'b1, idle_flags(1'b0, 1'b1, 1'b1));

    for (i = 0; i < steps.size(); i++) begin
      row_typed = steps[i].typed;
      row_want  = steps[i].want;
      put_word(steps[i].from_link, steps[i].ch);
    end
    row_typed = 1'b0;

    // Random part: well-formed commands half the time, the rest broken
    // lines, overlong lines, escape runs and plain noise
    while (words_sent < WORD_TARGET) begin
      if (words_sent < PHASE_ONE_END) begin
        src_idle_pct = 37;
        rcv_idle_pct = 65;
      end else if (words_sent < PHASE_TWO_END) begin
        src_idle_pct = 65;
        rcv_idle_pct = 37;
      end else begin
        // No idling from here on; hold the receiver off once so the block
        // fills up and pushes back on the sender
        if (holds_asked == 0) holds_asked = 1;
        src_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case ($urandom_range(0, 11))
        0, 1: load_text(STREAM_TXT, STREAM_N);
        2:    load_text(DISC_TXT, DISC_N);
        3, 4: begin
          load_text(START_TXT, START_N);
          line_buf.push_back(lcp_pkg::CH_CR);
          line_buf.push_back(lcp_pkg::CH_LF);
        end
        5: begin
          load_text(STOP_TXT, STOP_N);
          line_buf.push_back(lcp_pkg::CH_CR);
          line_buf.push_back(lcp_pkg::CH_LF);
        end
        6: begin
          // Command with one byte spoiled
          case ($urandom_range(0, 3))
            0:       load_text(START_TXT, START_N);
            1:       load_text(STOP_TXT, STOP_N);
            2:       load_text(STREAM_TXT, STREAM_N);
            default: load_text(DISC_TXT, DISC_N);
          endcase
          idx = $urandom_range(0, line_buf.size() - 1);
          line_buf[idx] = noise_byte();
          line_buf.push_back(lcp_pkg::CH_CR);
          line_buf.push_back(lcp_pkg::CH_LF);
        end
        7: begin
          // Short line of mixed bytes, sometimes missing its CR
          case ($urandom_range(0, 2))
            0:       line_buf.push_back(lcp_pkg::CH_PCT);
            1:       line_buf.push_back(lcp_pkg::CH_S);
            default: line_buf.push_back(8'($urandom_range(0, 255)));
          endcase
          repeat ($urandom_range(0, 10)) line_buf.push_back(noise_byte());
          if ($urandom_range(0, 3) != 0) line_buf.push_back(lcp_pkg::CH_CR);
          line_buf.push_back(lcp_pkg::CH_LF);
        end
        8: begin
          // Long printable line, mostly past the line limit, to wrap the line index
          line_buf.push_back(8'($urandom_range(65, 90)));
          repeat ($urandom_range(59, 75)) line_buf.push_back(8'($urandom_range(32, 126)));
        end
        9: begin
          // Escape into command mode, drop a few link bytes, escape out
          repeat (ESC_RUN) put_word(REQ_TERMINAL, lcp_pkg::CH_DOLLAR);
          repeat ($urandom_range(0, 3)) put_word(REQ_LINK, noise_byte());
          if ($urandom_range(0, 2) == 0) begin
            put_word(REQ_TERMINAL, lcp_pkg::CH_DASH);
            put_word(REQ_TERMINAL, noise_byte());
          end
          repeat (ESC_RUN) put_word(REQ_TERMINAL, lcp_pkg::CH_DASH);
        end
        10: begin
          // Terminal chatter, dollars and dashes among it
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
              0:       put_word(REQ_TERMINAL, lcp_pkg::CH_DOLLAR);
              1:       put_word(REQ_TERMINAL, lcp_pkg::CH_DASH);
              default: put_word(REQ_TERMINAL, 8'($urandom_range(0, 255)));
            endcase
          end
        end
        default: begin
          repeat ($urandom_range(1, 4))
            put_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
      endcase
      flush_line();
    end
    in_valid <= 1'b0;

    // Drain, then give the block time to show any stray result word
    while (pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d words and %0d result words, %0d entries into command mode",
             words_sent, results_seen, mode_entries);
    $display("Lines parsed: %0d, display actions: %0d, unknown lines: %0d, mismatches: %0d",
             lines_seen, actions_seen, unknown_seen, mismatches);
    if (mismatches == 0 && pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+sv
sv/lcp_pkg.sv
sv/link_command_parser.sv
sim/link_command_parser_tb.sv
